// ===== sv/tmcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared types and constants for the text-mode console writer.
// ----------------------------------------------------------------------------
package tmcw_pkg;

  // field widths on the stream ports
  localparam int CHAR_CODE_W  = 9;
  localparam int CELL_INDEX_W = 11;
  localparam int CURSOR_W     = 11;
  localparam int CELL_W       = 16;
  localparam int ATTR_W       = 8;
  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 32;

  // register reset and character codes
  localparam logic [ATTR_W-1:0]      ATTR_RESET     = 8'h07;
  localparam logic [CHAR_CODE_W-1:0] CODE_NEWLINE   = 9'd10;
  localparam logic [CHAR_CODE_W-1:0] CODE_BACKSPACE = 9'd256;
  localparam logic [7:0]             CHAR_SPACE     = 8'h20;

  // item kind carried on tuser
  typedef enum logic {
    OP_PUT  = 1'b0,
    OP_READ = 1'b1
  } tmcw_op_e;

  // command fields passed from the front end to the back end
  typedef struct packed {
    logic       is_read;
    logic       rd_ok;
    logic       wr_char;
    logic       scroll;
    logic [7:0] char_byte;
  } tmcw_cmd_t;

endpackage

// ===== sv/tmcw_ram.sv =====
// ----------------------------------------------------------------------------
// tmcw_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tmcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1920
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/tmcw_queue.sv =====
// ----------------------------------------------------------------------------
// tmcw_queue
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tmcw_queue #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] head_data_o,
  output logic             valid_o,
  output logic             full_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign valid_o     = (count_q != '0);
  assign full_o      = (count_q == CNT_W'(DEPTH));
  assign head_data_o = entry_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/tmcw_front.sv =====
// ----------------------------------------------------------------------------
// tmcw_front
// Accepts items, keeps the cursor and turns each item into a back-end command.
// ----------------------------------------------------------------------------
module tmcw_front #(
  parameter int COLUMNS     = 80,
  parameter int SCROLL_ROWS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                opcode_i,
  input  logic [tmcw_pkg::CHAR_CODE_W-1:0]    char_code_i,
  input  logic [tmcw_pkg::CELL_INDEX_W-1:0]   cell_index_i,
  input  logic                                init_done_i,
  input  logic                                q_full_i,
  output logic                                q_push_o,
  output logic [$bits(tmcw_pkg::tmcw_cmd_t)
                + 2*$clog2(SCROLL_ROWS*COLUMNS)-1:0] q_data_o
);

  import tmcw_pkg::*;

  localparam int SCROLL_LIMIT = SCROLL_ROWS * COLUMNS;
  localparam int ADDR_W       = $clog2(SCROLL_LIMIT);
  localparam int CUR_W        = $clog2(SCROLL_LIMIT + 1);
  localparam int COL_W        = $clog2(COLUMNS);

  logic [ADDR_W-1:0] cursor_q, cursor_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [CUR_W-1:0]  moved;
  logic              accept;
  tmcw_cmd_t         cmd;
  logic [ADDR_W-1:0] addr;

  assign in_ready_o = init_done_i && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept;

  // classify the item and move the cursor
  always_comb begin
    moved         = CUR_W'(cursor_q);
    col_d         = col_q;
    cmd.is_read   = (tmcw_op_e'(opcode_i) == OP_READ);
    cmd.rd_ok     = (32'(cell_index_i) < 32'(SCROLL_LIMIT));
    cmd.wr_char   = 1'b0;
    cmd.scroll    = 1'b0;
    cmd.char_byte = char_code_i[7:0];
    priority if (char_code_i == CODE_NEWLINE) begin
      moved = CUR_W'(cursor_q) + CUR_W'(COLUMNS) - CUR_W'(col_q);
      col_d = '0;
    end else if (char_code_i == CODE_BACKSPACE) begin
      if (cursor_q != '0) begin
        moved = CUR_W'(cursor_q) - 1'b1;
        col_d = (col_q == '0) ? COL_W'(COLUMNS - 1) : col_q - 1'b1;
      end
    end else begin
      moved       = CUR_W'(cursor_q) + 1'b1;
      col_d       = (col_q == COL_W'(COLUMNS - 1)) ? '0 : col_q + 1'b1;
      cmd.wr_char = 1'b1;
    end
    // reaching the scroll row pulls the cursor back one row
    cmd.scroll = (moved == CUR_W'(SCROLL_LIMIT));
    cursor_d   = cmd.scroll ? ADDR_W'(moved - CUR_W'(COLUMNS)) : ADDR_W'(moved);
    if (cmd.is_read) begin
      cmd.wr_char = 1'b0;
      cmd.scroll  = 1'b0;
      cursor_d    = cursor_q;
      col_d       = col_q;
    end
    addr = cmd.is_read ? ADDR_W'(cell_index_i) : cursor_q;
  end

  assign q_data_o = {cmd, addr, cursor_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      col_q    <= '0;
    end else if (accept) begin
      cursor_q <= cursor_d;
      col_q    <= col_d;
    end
  end

endmodule

// ===== sv/tmcw_back.sv =====
// ----------------------------------------------------------------------------
// tmcw_back
// Executes commands on the screen store: writes, scroll copy, reads, results.
// ----------------------------------------------------------------------------
module tmcw_back #(
  parameter int COLUMNS     = 80,
  parameter int SCROLL_ROWS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [tmcw_pkg::ATTR_W-1:0]         attr_i,
  input  logic                                q_valid_i,
  input  logic [$bits(tmcw_pkg::tmcw_cmd_t)
                + 2*$clog2(SCROLL_ROWS*COLUMNS)-1:0] q_data_i,
  output logic                                q_pop_o,
  output logic                                init_done_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [tmcw_pkg::CURSOR_W-1:0]       out_cursor_o,
  output logic [tmcw_pkg::CELL_W-1:0]         out_data_o
);

  import tmcw_pkg::*;

  localparam int SCROLL_LIMIT = SCROLL_ROWS * COLUMNS;
  localparam int COPY_CELLS   = (SCROLL_ROWS - 1) * COLUMNS;
  localparam int ADDR_W       = $clog2(SCROLL_LIMIT);
  localparam int CMD_W        = $bits(tmcw_cmd_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COPY,
    ST_FILL,
    ST_SPACE,
    ST_RD,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [ADDR_W-1:0] cnt_q;
  tmcw_cmd_t         cur_cmd_q;
  logic [ADDR_W-1:0] cur_cursor_q;
  logic [CELL_W-1:0] data_q;
  logic              out_valid_q;
  logic [CURSOR_W-1:0] out_cursor_q;
  logic [CELL_W-1:0] out_data_q;

  tmcw_cmd_t         head_cmd;
  logic [ADDR_W-1:0] head_addr;
  logic [ADDR_W-1:0] head_cursor;
  logic              out_free;
  logic              out_load;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;
  logic [CELL_W-1:0] rd_value;

  assign head_cmd    = tmcw_cmd_t'(q_data_i[CMD_W + 2*ADDR_W - 1 -: CMD_W]);
  assign head_addr   = q_data_i[2*ADDR_W-1 -: ADDR_W];
  assign head_cursor = q_data_i[ADDR_W-1:0];
  assign out_free    = !out_valid_q || out_ready_i;
  // result register loads in this cycle
  assign out_load    = out_free && ((state_q == ST_SPACE) || (state_q == ST_RD) ||
                                    (state_q == ST_DONE));
  assign q_pop_o     = (state_q == ST_IDLE) && q_valid_i;
  assign init_done_o = (state_q != ST_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_cursor_o = out_cursor_q;
  assign out_data_o  = out_data_q;
  assign rd_value    = cur_cmd_q.rd_ok ? ram_rdata : '0;

  tmcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (SCROLL_LIMIT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // memory port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state_q)
      ST_CLEAR, ST_FILL: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        ram_raddr = head_addr;
        ram_waddr = head_addr;
        ram_wdata = {attr_i, head_cmd.char_byte};
        ram_we    = q_valid_i && head_cmd.wr_char;
      end
      ST_COPY: begin
        // read one row ahead, write what came back on the next cycle
        if (cnt_q != ADDR_W'(COPY_CELLS)) begin
          ram_raddr = cnt_q + ADDR_W'(COLUMNS);
        end
        ram_we    = (cnt_q != '0);
        ram_waddr = cnt_q - 1'b1;
        ram_wdata = ram_rdata;
      end
      ST_SPACE: begin
        ram_we    = 1'b1;
        ram_waddr = cur_cursor_q;
        ram_wdata = {attr_i, CHAR_SPACE};
      end
      ST_RD, ST_DONE: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cnt_q        <= '0;
      cur_cmd_q    <= '0;
      cur_cursor_q <= '0;
      data_q       <= '0;
      out_valid_q  <= 1'b0;
      out_cursor_q <= '0;
      out_data_q   <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          if (cnt_q == ADDR_W'(SCROLL_LIMIT - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (q_valid_i) begin
            cur_cmd_q    <= head_cmd;
            cur_cursor_q <= head_cursor;
            cnt_q        <= '0;
            if (head_cmd.is_read) begin
              state_q <= ST_RD;
            end else if (head_cmd.scroll) begin
              state_q <= ST_COPY;
            end else begin
              state_q <= ST_SPACE;
            end
          end
        end
        ST_COPY: begin
          if (cnt_q == ADDR_W'(COPY_CELLS)) begin
            state_q <= ST_FILL;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_FILL: begin
          if (cnt_q == ADDR_W'(SCROLL_LIMIT - 1)) begin
            state_q <= ST_SPACE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_SPACE: begin
          data_q <= '0;
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_cursor_q <= CURSOR_W'(cur_cursor_q);
            out_data_q   <= '0;
            state_q      <= ST_IDLE;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_RD: begin
          data_q <= rd_value;
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_cursor_q <= CURSOR_W'(cur_cursor_q);
            out_data_q   <= rd_value;
            state_q      <= ST_IDLE;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_cursor_q <= CURSOR_W'(cur_cursor_q);
            out_data_q   <= data_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/text_mode_console_writer_core.sv =====
// Flow: a put or a read without scroll waits at the queue head until the back end pops it
//   in the idle state; a space-write or read-data step then loads the result register.
// The back end pops the next item only after loading the result of the last one, which
//   waits while the output is busy; a scroll adds the row copy and fill passes first.
// Reset: cursor and attribute (7) reset at once; a clearing pass then zeroes
//   the SCROLL_ROWS*COLUMNS screen cells, one per cycle, before items are taken.
// ----------------------------------------------------------------------------
// text_mode_console_writer_core
// Text-mode screen writer with cursor, scrolling and cell read-back.
// ----------------------------------------------------------------------------
module text_mode_console_writer_core #(
  parameter int COLUMNS     = 80,
  parameter int SCROLL_ROWS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration: text_attribute
  input  logic                              cfg_we_i,
  input  logic [tmcw_pkg::ATTR_W-1:0]       cfg_wdata_i,
  // input items
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // char_code [8:0], cell_index [19:9]
  input  logic [tmcw_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // opcode [0]
  input  logic [0:0]                        s_axis_tuser_i,
  // result items
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // cursor_pos [10:0], cell_data [26:11]
  output logic [tmcw_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);

  import tmcw_pkg::*;

  localparam int ADDR_W = $clog2(SCROLL_ROWS * COLUMNS);
  localparam int QW     = $bits(tmcw_cmd_t) + 2 * ADDR_W;

  logic [ATTR_W-1:0]   attr_q;
  logic                q_push;
  logic                q_pop;
  logic                q_valid;
  logic                q_full;
  logic [QW-1:0]       q_push_data;
  logic [QW-1:0]       q_head_data;
  logic                init_done;
  logic [CURSOR_W-1:0] out_cursor;
  logic [CELL_W-1:0]   out_data;

  // attribute register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  // front end: cursor tracking and command build
  tmcw_front #(
    .COLUMNS     (COLUMNS),
    .SCROLL_ROWS (SCROLL_ROWS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .opcode_i     (s_axis_tuser_i[0]),
    .char_code_i  (s_axis_tdata_i[CHAR_CODE_W-1:0]),
    .cell_index_i (s_axis_tdata_i[CHAR_CODE_W +: CELL_INDEX_W]),
    .init_done_i  (init_done),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_data_o     (q_push_data)
  );

  // command queue
  tmcw_queue #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .head_data_o (q_head_data),
    .valid_o     (q_valid),
    .full_o      (q_full)
  );

  // back end: screen store and result register
  tmcw_back #(
    .COLUMNS     (COLUMNS),
    .SCROLL_ROWS (SCROLL_ROWS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .attr_i       (attr_q),
    .q_valid_i    (q_valid),
    .q_data_i     (q_head_data),
    .q_pop_o      (q_pop),
    .init_done_o  (init_done),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_cursor_o (out_cursor),
    .out_data_o   (out_data)
  );

  assign m_axis_tdata_o = {(OUT_TDATA_W - CURSOR_W - CELL_W)'(0), out_data, out_cursor};

  // queue is never written when full
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("command queue overflow");

  // back end only pops a valid entry
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("command queue underflow");

  // no input transfer while the store is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |-> init_done)
    else $error("item taken during clearing pass");

  // no command is queued while clearing; pops come only from the idle state
  assert property (@(posedge clk_i) disable iff (!rst_ni) !init_done |-> !q_valid)
    else $error("command queued before clearing pass finished");

endmodule
